/* rtl/mvdec_pkg.sv */
// Package for the 8086 MOV decoder: record type, kind codes, opcode patterns
// and the opcode classifier. It has no dependencies.
package mvdec_pkg;

    // Record kinds.
    localparam logic [2:0] KIND_RM_REG    = 3'd0;
    localparam logic [2:0] KIND_IMM_RM    = 3'd1;
    localparam logic [2:0] KIND_IMM_REG   = 3'd2;
    localparam logic [2:0] KIND_MEM_ACC   = 3'd3;
    localparam logic [2:0] KIND_ACC_MEM   = 3'd4;
    localparam logic [2:0] KIND_UNSUP     = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd6;

    // Opcode masks and patterns.
    localparam logic [7:0] MASK_RM_REG    = 8'hFC;
    localparam logic [7:0] BITS_RM_REG    = 8'h88;
    localparam logic [7:0] MASK_W1        = 8'hFE;
    localparam logic [7:0] BITS_IMM_RM    = 8'hC6;
    localparam logic [7:0] MASK_IMM_REG   = 8'hF0;
    localparam logic [7:0] BITS_IMM_REG   = 8'hB0;
    localparam logic [7:0] BITS_MEM_ACC   = 8'hA0;
    localparam logic [7:0] BITS_ACC_MEM   = 8'hA2;
    localparam logic [7:0] OP_SEG_TO      = 8'h8E;
    localparam logic [7:0] OP_SEG_FROM    = 8'h8C;
    localparam logic [7:0] MODRM_REG_MASK = 8'h38;
    localparam logic [7:0] MODRM_MOD_MASK = 8'hC0;

    // One decoded record.
    typedef struct packed {
        logic [2:0]  kind;
        logic        direction;
        logic        wide;
        logic [1:0]  addr_mode;
        logic [2:0]  reg_select;
        logic [2:0]  rm_select;
        logic        direct_mem;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  length;
    } result_t;

    // Map an opcode byte to the form it opens.
    function automatic logic [2:0] classify(input logic [7:0] op);
        logic [2:0] k;
        if ((op & MASK_RM_REG) == BITS_RM_REG)       k = KIND_RM_REG;
        else if ((op & MASK_W1) == BITS_IMM_RM)      k = KIND_IMM_RM;
        else if ((op & MASK_IMM_REG) == BITS_IMM_REG) k = KIND_IMM_REG;
        else if ((op & MASK_W1) == BITS_MEM_ACC)     k = KIND_MEM_ACC;
        else if ((op & MASK_W1) == BITS_ACC_MEM)     k = KIND_ACC_MEM;
        else if (op == OP_SEG_TO || op == OP_SEG_FROM) k = KIND_UNSUP;
        else                                         k = KIND_UNKNOWN;
        return k;
    endfunction

    // Operand width bit; the immediate-to-register form keeps it in bit 3.
    function automatic logic wide_of(input logic [7:0] op);
        logic w;
        if (classify(op) == KIND_IMM_REG) w = op[3];
        else                              w = op[0];
        return w;
    endfunction

endpackage

/* rtl/mvdec_in_stage.sv */
// Input register of the MOV decoder: holds one code byte until it is decoded.
// Depends on nothing but the clock and reset.
module mvdec_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] code_byte,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic       advance,
    output logic       full,
    output logic [7:0] held_byte
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;
    logic       take;

    // A new byte can enter whenever the held one is consumed this cycle.
    assign byte_stall = full_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        if (take)
            full_next = 1'b1;
        else if (advance)
            full_next = 1'b0;
        else
            full_next = full_reg;
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    // Byte payload register.
    always_ff @(posedge clk)
    begin
        if (take)
            byte_reg <= code_byte;
    end

    assign full      = full_reg;
    assign held_byte = byte_reg;

endmodule

/* rtl/mvdec_decode.sv */
// Decode core of the MOV decoder: phase and gathered fields, and the record
// that the current byte completes. Depends on mvdec_pkg.
module mvdec_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          held_byte,
    input  logic                advance,
    output logic                emit,
    output mvdec_pkg::result_t  rec
);

    localparam logic [2:0] PH_OPCODE = 3'd0;
    localparam logic [2:0] PH_MODRM  = 3'd1;
    localparam logic [2:0] PH_DISPLO = 3'd2;
    localparam logic [2:0] PH_DISPHI = 3'd3;
    localparam logic [2:0] PH_IMMLO  = 3'd4;
    localparam logic [2:0] PH_IMMHI  = 3'd5;

    logic [2:0]  phase_reg,  phase_next;
    logic [7:0]  op_reg,     op_next;
    logic [7:0]  modrm_reg,  modrm_next;
    logic [15:0] disp_reg,   disp_next;
    logic [15:0] imm_reg,    imm_next;
    logic [2:0]  count_reg,  count_next;
    logic [2:0]  emit_kind;
    logic [2:0]  k_held;
    logic [2:0]  k_byte;
    logic [1:0]  mod_n;
    logic [2:0]  rm_n;
    logic        direct_n;

    assign k_held = mvdec_pkg::classify(op_reg);
    assign k_byte = mvdec_pkg::classify(held_byte);

    // Next state and whether this byte finishes an instruction.
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        modrm_next = modrm_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        count_next = 3'(count_reg + 3'd1);
        emit       = 1'b0;
        emit_kind  = k_held;
        case (phase_reg)
            PH_MODRM:
            begin
                modrm_next = held_byte;
                if (k_held == mvdec_pkg::KIND_UNSUP ||
                    (k_held == mvdec_pkg::KIND_IMM_RM &&
                     (held_byte & mvdec_pkg::MODRM_REG_MASK) != 8'h00))
                begin
                    emit      = 1'b1;
                    emit_kind = mvdec_pkg::KIND_UNSUP;
                end
                else if (held_byte[7:6] == 2'd1 || held_byte[7:6] == 2'd2 ||
                         (held_byte[7:6] == 2'd0 && held_byte[2:0] == 3'd6))
                    phase_next = PH_DISPLO;
                else if (k_held == mvdec_pkg::KIND_IMM_RM)
                    phase_next = PH_IMMLO;
                else
                    emit = 1'b1;
            end
            PH_DISPLO:
            begin
                disp_next = {8'h00, held_byte};
                if (k_held == mvdec_pkg::KIND_MEM_ACC ||
                    k_held == mvdec_pkg::KIND_ACC_MEM ||
                    modrm_reg[7:6] == 2'd2 ||
                    (modrm_reg[7:6] == 2'd0 && modrm_reg[2:0] == 3'd6))
                    phase_next = PH_DISPHI;
                else
                begin
                    // Short displacement is sign-extended.
                    if (held_byte[7])
                        disp_next[15:8] = 8'hFF;
                    if (k_held == mvdec_pkg::KIND_IMM_RM)
                        phase_next = PH_IMMLO;
                    else
                        emit = 1'b1;
                end
            end
            PH_DISPHI:
            begin
                disp_next = {held_byte, disp_reg[7:0]};
                if (k_held == mvdec_pkg::KIND_IMM_RM)
                    phase_next = PH_IMMLO;
                else
                    emit = 1'b1;
            end
            PH_IMMLO:
            begin
                imm_next = {8'h00, held_byte};
                if (mvdec_pkg::wide_of(op_reg))
                    phase_next = PH_IMMHI;
                else
                    emit = 1'b1;
            end
            PH_IMMHI:
            begin
                imm_next = {held_byte, imm_reg[7:0]};
                emit     = 1'b1;
            end
            default:
            begin
                // Opcode byte; unknown phase codes land here as well.
                op_next    = held_byte;
                modrm_next = 8'h00;
                disp_next  = 16'h0000;
                imm_next   = 16'h0000;
                count_next = 3'd1;
                emit_kind  = k_byte;
                case (k_byte)
                    mvdec_pkg::KIND_RM_REG,
                    mvdec_pkg::KIND_IMM_RM,
                    mvdec_pkg::KIND_UNSUP:   phase_next = PH_MODRM;
                    mvdec_pkg::KIND_IMM_REG: phase_next = PH_IMMLO;
                    mvdec_pkg::KIND_MEM_ACC,
                    mvdec_pkg::KIND_ACC_MEM: phase_next = PH_DISPLO;
                    default:                 emit = 1'b1;
                endcase
            end
        endcase
        if (emit)
            phase_next = PH_OPCODE;
    end

    assign mod_n    = modrm_next[7:6];
    assign rm_n     = modrm_next[2:0];
    assign direct_n = (mod_n == 2'd0) && (rm_n == 3'd6);

    // Record fields; anything without meaning for the kind stays zero.
    always_comb
    begin
        rec        = '0;
        rec.kind   = emit_kind;
        rec.length = count_next;
        case (emit_kind)
            mvdec_pkg::KIND_RM_REG, mvdec_pkg::KIND_IMM_RM:
            begin
                rec.direction    = (emit_kind == mvdec_pkg::KIND_RM_REG) && op_next[1];
                rec.wide         = op_next[0];
                rec.addr_mode    = mod_n;
                rec.reg_select   = (emit_kind == mvdec_pkg::KIND_RM_REG) ?
                                   modrm_next[5:3] : 3'd0;
                rec.rm_select    = rm_n;
                rec.direct_mem   = direct_n;
                rec.displacement = disp_next;
                rec.immediate    = (emit_kind == mvdec_pkg::KIND_IMM_RM) ?
                                   imm_next : 16'h0000;
            end
            mvdec_pkg::KIND_IMM_REG:
            begin
                rec.direction  = 1'b1;
                rec.wide       = op_next[3];
                rec.reg_select = op_next[2:0];
                rec.immediate  = imm_next;
            end
            mvdec_pkg::KIND_MEM_ACC, mvdec_pkg::KIND_ACC_MEM:
            begin
                rec.direction    = (emit_kind == mvdec_pkg::KIND_MEM_ACC);
                rec.wide         = op_next[0];
                rec.direct_mem   = 1'b1;
                rec.displacement = disp_next;
            end
            mvdec_pkg::KIND_UNSUP:
            begin
                rec.direction  = op_next[1];
                rec.wide       = op_next[0];
                rec.addr_mode  = mod_n;
                rec.reg_select = modrm_next[5:3];
                rec.rm_select  = rm_n;
            end
            default:
            begin
                rec.kind = emit_kind;
            end
        endcase
    end

    // Decoder state, updated once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPCODE;
            op_reg    <= 8'h00;
            modrm_reg <= 8'h00;
            disp_reg  <= 16'h0000;
            imm_reg   <= 16'h0000;
            count_reg <= 3'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            modrm_reg <= modrm_next;
            disp_reg  <= disp_next;
            imm_reg   <= imm_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/mvdec_out_stage.sv */
// Output register of the MOV decoder: holds a finished record until taken and
// decides when the held byte may be consumed. Depends on mvdec_pkg.
module mvdec_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               full,
    input  logic               emit,
    input  mvdec_pkg::result_t rec,
    output logic               advance,
    output logic               rec_valid,
    input  logic               rec_stall,
    output mvdec_pkg::result_t rec_out
);

    logic               valid_reg;
    logic               valid_next;
    mvdec_pkg::result_t rec_reg;
    logic               load;

    // A byte that makes no record never waits on the output side.
    assign advance = full && (!emit || !valid_reg || !rec_stall);
    assign load    = advance && emit;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!rec_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // Record valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Record payload register.
    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= rec;
    end

    assign rec_valid = valid_reg;
    assign rec_out   = rec_reg;

endmodule

/* rtl/x86_16_mov_instruction_decoder.sv */
// Top level of the 8086 MOV decoder: input register, decode core, record register.
// Depends on mvdec_pkg, mvdec_in_stage, mvdec_decode and mvdec_out_stage.
//
//   Channel   Handshake                Payload
//   bytes     byte_valid / byte_stall  code_byte
//   records   rec_valid / rec_stall    kind .. length (ten fields)
//
// One code byte per cycle is sustained unless a stalled record holds it back;
// each record is registered as its last byte leaves the byte register.
// The decode step sits between the byte register and the record register.
// Reset (rst_n low) empties both registers and returns to waiting for an opcode.
// A stalled record holds only bytes that would make a new record; other bytes
// keep flowing.
module x86_16_mov_instruction_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  code_byte,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic [2:0]  kind,
    output logic        direction,
    output logic        wide,
    output logic [1:0]  addr_mode,
    output logic [2:0]  reg_select,
    output logic [2:0]  rm_select,
    output logic        direct_mem,
    output logic [15:0] displacement,
    output logic [15:0] immediate,
    output logic [2:0]  length,
    output logic        rec_valid,
    input  logic        rec_stall
);

    logic               full;
    logic [7:0]         held_byte;
    logic               advance;
    logic               emit;
    mvdec_pkg::result_t rec;
    mvdec_pkg::result_t rec_out;

    // Byte register.
    mvdec_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_byte  (code_byte),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .advance    (advance),
        .full       (full),
        .held_byte  (held_byte)
    );

    // Decode core.
    mvdec_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .held_byte (held_byte),
        .advance   (advance),
        .emit      (emit),
        .rec       (rec)
    );

    // Record register.
    mvdec_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .full      (full),
        .emit      (emit),
        .rec       (rec),
        .advance   (advance),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_out   (rec_out)
    );

    assign kind         = rec_out.kind;
    assign direction    = rec_out.direction;
    assign wide         = rec_out.wide;
    assign addr_mode    = rec_out.addr_mode;
    assign reg_select   = rec_out.reg_select;
    assign rm_select    = rec_out.rm_select;
    assign direct_mem   = rec_out.direct_mem;
    assign displacement = rec_out.displacement;
    assign immediate    = rec_out.immediate;
    assign length       = rec_out.length;

endmodule

/* rtl/mvdec_checker.sv */
// Port-level checks for the 8086 MOV decoder, bound to its top level.
// Depends on mvdec_pkg and x86_16_mov_instruction_decoder.
module mvdec_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  code_byte,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [2:0]  kind,
    input  logic        direction,
    input  logic        wide,
    input  logic [1:0]  addr_mode,
    input  logic [2:0]  reg_select,
    input  logic [2:0]  rm_select,
    input  logic        direct_mem,
    input  logic [15:0] displacement,
    input  logic [15:0] immediate,
    input  logic [2:0]  length,
    input  logic        rec_valid,
    input  logic        rec_stall
);

    // A stalled record transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_stall |=> rec_valid)
        else $error("record dropped while stalled");

    // An unknown opcode uses exactly one byte and carries nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && kind == mvdec_pkg::KIND_UNKNOWN |->
            length == 3'd1 && displacement == 16'h0000 && immediate == 16'h0000)
        else $error("unknown opcode record malformed");

    // Accumulator moves are always three bytes with a direct address.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (kind == mvdec_pkg::KIND_MEM_ACC ||
                      kind == mvdec_pkg::KIND_ACC_MEM) |->
            direct_mem && length == 3'd3 && reg_select == 3'd0)
        else $error("accumulator move record malformed");

    // A byte-wide immediate to register is two bytes with a zero high half.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && kind == mvdec_pkg::KIND_IMM_REG && !wide |->
            length == 3'd2 && immediate[15:8] == 8'h00 && direction)
        else $error("byte immediate record malformed");

endmodule

bind x86_16_mov_instruction_decoder mvdec_checker u_mvdec_checker (.*);
